// ----- rtl/segment_sphere_intersection_core_defines.svh -----
// Assertion macros shared by the segment / sphere intersection RTL.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef SEGMENT_SPHERE_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_SPHERE_INTERSECTION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_sphere_intersection_core: assertion failed");

// Next-cycle implication, checked outside reset.
`define SSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_sphere_intersection_core: assertion failed");

`endif

// ----- rtl/ssi_pkg.sv -----
// Package for the segment / sphere intersection core: payload structs,
// register indexes and the pipeline context type. Depends on nothing.
`timescale 1ns / 1ps

package ssi_pkg;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] stop_x;
        logic signed [31:0] stop_y;
        logic signed [31:0] stop_z;
    } seg_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } res_t;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_CENTER_X = 3'd0;
    localparam cfg_idx_t REG_CENTER_Y = 3'd1;
    localparam cfg_idx_t REG_CENTER_Z = 3'd2;
    localparam cfg_idx_t REG_RADIUS   = 3'd3;

    // Quadratic term widths: a = d.d is unsigned, h = d.f and c = f.f - r*r signed.
    localparam int AW  = 66;
    localparam int HW  = 67;
    localparam int LW  = 22;
    localparam int PPW = 2 * LW;
    localparam int RSW = 4 * LW;
    localparam int SQW = 6 * LW;

    // Per-item data that travels with the root and divide pipelines.
    typedef struct packed {
        logic                  miss;
        logic                  dzero;
        logic [AW-1:0]         a;
        logic signed [HW-1:0]  h;
        logic [2:0][32:0]      d;
        logic [2:0][31:0]      b;
    } ctx_t;

endpackage

// ----- rtl/segment_sphere_intersection_core.sv -----
// Segment / sphere intersection core, fully pipelined, one segment per cycle.
// Its depth is set by the one-bit-per-stage square root and the two quotient pipelines.
// Throughput: one transfer per cycle; busy is never raised and done cannot stall.
// Reset clears all valid bits and loads center 0, radius 1.0; no clearing pass.
// Depends on ssi_pkg and segment_sphere_intersection_core_defines.svh.
`timescale 1ns / 1ps
`include "segment_sphere_intersection_core_defines.svh"

module segment_sphere_intersection_core #(
    parameter int PARAM_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ssi_pkg::seg_t      seg,
    output logic               done,
    output ssi_pkg::res_t      result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ssi_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]        cfg_data
);

    // The parameter of the segment, mu, has P fraction bits. The root s has SW bits,
    // the shifted numerators NW bits, and the quotient QS bits (mu + 2^(P+1)).
    localparam int P   = PARAM_FRAC_BITS;
    localparam int SW  = 66 + P;
    localparam int RW  = SW + 2;
    localparam int NW  = P + 70;
    localparam int QS  = P + 2;
    localparam int PRW = QS + 33;
    localparam int PTW = QS + 34;
    localparam int LAT = 80 + 2 * P;

    localparam longint unsigned EPS_L = ((64'd1 << P) + 64'd5000) / 64'd10000;
    localparam logic [QS:0] EPS    = (QS + 1)'(EPS_L);
    localparam logic [QS:0] ONE    = (QS + 1)'(1) << P;
    localparam logic [QS:0] C0     = (QS + 1)'(1) << (P + 1);
    localparam logic [QS:0] WIN_LO = C0 - EPS;
    localparam logic [QS:0] WIN_HI = C0 + ONE + EPS;
    localparam logic [QS:0] Z_LO   = C0 + EPS;
    localparam logic [QS:0] Z_HI   = C0 + ONE;

    // The pipeline never stalls, so a new segment is taken in every cycle and
    // configuration writes complete at once.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while the pipe is
    // empty, which the block itself does not enforce; the stages read them directly.
    // ------------------------------------------------------------------
    logic signed [31:0] cen_reg [3];
    logic [30:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
            rad_reg    <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssi_pkg::REG_CENTER_X: cen_reg[0] <= cfg_data;
                ssi_pkg::REG_CENTER_Y: cen_reg[1] <= cfg_data;
                ssi_pkg::REG_CENTER_Z: cen_reg[2] <= cfg_data;
                ssi_pkg::REG_RADIUS:   rad_reg    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: direction d = stop - start and offset f = start - center.
    // ------------------------------------------------------------------
    logic signed [31:0] in_b [3];
    logic signed [31:0] in_e [3];

    always_comb
    begin
        in_b[0] = seg.start_x;
        in_b[1] = seg.start_y;
        in_b[2] = seg.start_z;
        in_e[0] = seg.stop_x;
        in_e[1] = seg.stop_y;
        in_e[2] = seg.stop_z;
    end

    logic               v1_reg;
    logic signed [32:0] d1_reg [3];
    logic signed [32:0] f1_reg [3];
    logic signed [31:0] b1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i] <= 33'(in_e[i]) - 33'(in_b[i]);
            f1_reg[i] <= 33'(in_b[i]) - 33'(cen_reg[i]);
            b1_reg[i] <= in_b[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the nine coordinate products and r*r.
    // ------------------------------------------------------------------
    logic               v2_reg;
    logic signed [65:0] dd2_reg [3];
    logic signed [65:0] df2_reg [3];
    logic signed [65:0] ff2_reg [3];
    logic [61:0]        rr2_reg;
    logic signed [32:0] d2_reg [3];
    logic signed [31:0] b2_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd2_reg[i] <= d1_reg[i] * d1_reg[i];
            df2_reg[i] <= d1_reg[i] * f1_reg[i];
            ff2_reg[i] <= f1_reg[i] * f1_reg[i];
            d2_reg[i]  <= d1_reg[i];
            b2_reg[i]  <= b1_reg[i];
        end
        rr2_reg <= 62'(rad_reg) * 62'(rad_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: a, h and c; a and h are packed into the context that follows the item.
    // ------------------------------------------------------------------
    logic          v3_reg;
    ssi_pkg::ctx_t ctx3_reg;
    logic signed [ssi_pkg::HW-1:0] c3_reg;
    ssi_pkg::ctx_t ctx3_next;

    always_comb
    begin
        ctx3_next       = '0;
        ctx3_next.a     = ssi_pkg::AW'(dd2_reg[0]) + ssi_pkg::AW'(dd2_reg[1])
                        + ssi_pkg::AW'(dd2_reg[2]);
        ctx3_next.h     = ssi_pkg::HW'(df2_reg[0]) + ssi_pkg::HW'(df2_reg[1])
                        + ssi_pkg::HW'(df2_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            ctx3_next.d[i] = d2_reg[i];
            ctx3_next.b[i] = b2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        ctx3_reg <= ctx3_next;
        c3_reg   <= ssi_pkg::HW'(ff2_reg[0]) + ssi_pkg::HW'(ff2_reg[1])
                  + ssi_pkg::HW'(ff2_reg[2]) - ssi_pkg::HW'(rr2_reg);
    end

    // ------------------------------------------------------------------
    // Stage 4: limb products for h*h and a*|c| on 22-bit limbs.
    // ------------------------------------------------------------------
    logic [ssi_pkg::HW-1:0] hm_full;
    logic [ssi_pkg::HW-1:0] cm_full;
    logic [ssi_pkg::LW-1:0] hl [3];
    logic [ssi_pkg::LW-1:0] al [3];
    logic [ssi_pkg::LW-1:0] cl [3];
    ssi_pkg::ctx_t          ctx4_next;

    always_comb
    begin
        hm_full = ctx3_reg.h[ssi_pkg::HW-1] ? ssi_pkg::HW'(-ctx3_reg.h) : ctx3_reg.h;
        cm_full = c3_reg[ssi_pkg::HW-1] ? ssi_pkg::HW'(-c3_reg) : c3_reg;
        for (int i = 0; i < 3; i++)
        begin
            hl[i] = hm_full[ssi_pkg::LW*i +: ssi_pkg::LW];
            al[i] = ctx3_reg.a[ssi_pkg::LW*i +: ssi_pkg::LW];
            cl[i] = cm_full[ssi_pkg::LW*i +: ssi_pkg::LW];
        end
        // A degenerate segment has no direction and always misses.
        ctx4_next      = ctx3_reg;
        ctx4_next.miss = (ctx3_reg.a == '0);
    end

    logic                    v4_reg;
    ssi_pkg::ctx_t           ctx4_reg;
    logic                    cneg4_reg;
    logic [ssi_pkg::PPW-1:0] phh4_reg [3][3];
    logic [ssi_pkg::PPW-1:0] pac4_reg [3][3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                phh4_reg[i][j] <= ssi_pkg::PPW'(hl[i]) * ssi_pkg::PPW'(hl[j]);
                pac4_reg[i][j] <= ssi_pkg::PPW'(al[i]) * ssi_pkg::PPW'(cl[j]);
            end
        end
        ctx4_reg      <= ctx4_next;
        cneg4_reg     <= c3_reg[ssi_pkg::HW-1];
    end

    // ------------------------------------------------------------------
    // Stages 5 and 6: row sums, then the full 132-bit products.
    // ------------------------------------------------------------------
    logic                    v5_reg;
    ssi_pkg::ctx_t           ctx5_reg;
    logic                    cneg5_reg;
    logic [ssi_pkg::RSW-1:0] rhh5_reg [3];
    logic [ssi_pkg::RSW-1:0] rac5_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rhh5_reg[i] <= ssi_pkg::RSW'(phh4_reg[i][0])
                         + (ssi_pkg::RSW'(phh4_reg[i][1]) << ssi_pkg::LW)
                         + (ssi_pkg::RSW'(phh4_reg[i][2]) << (2 * ssi_pkg::LW));
            rac5_reg[i] <= ssi_pkg::RSW'(pac4_reg[i][0])
                         + (ssi_pkg::RSW'(pac4_reg[i][1]) << ssi_pkg::LW)
                         + (ssi_pkg::RSW'(pac4_reg[i][2]) << (2 * ssi_pkg::LW));
        end
        ctx5_reg  <= ctx4_reg;
        cneg5_reg <= cneg4_reg;
    end

    logic                    v6_reg;
    ssi_pkg::ctx_t           ctx6_reg;
    logic                    cneg6_reg;
    logic [ssi_pkg::SQW-1:0] hh6_reg;
    logic [ssi_pkg::SQW-1:0] ac6_reg;

    always_ff @(posedge clk)
    begin
        hh6_reg   <= ssi_pkg::SQW'(rhh5_reg[0])
                   + (ssi_pkg::SQW'(rhh5_reg[1]) << ssi_pkg::LW)
                   + (ssi_pkg::SQW'(rhh5_reg[2]) << (2 * ssi_pkg::LW));
        ac6_reg   <= ssi_pkg::SQW'(rac5_reg[0])
                   + (ssi_pkg::SQW'(rac5_reg[1]) << ssi_pkg::LW)
                   + (ssi_pkg::SQW'(rac5_reg[2]) << (2 * ssi_pkg::LW));
        ctx6_reg  <= ctx5_reg;
        cneg6_reg <= cneg5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: discriminant D = h*h - a*c, its sign and whether it is zero.
    // This stage is entry 0 of the square root pipeline.
    // ------------------------------------------------------------------
    logic [ssi_pkg::SQW:0] disc7;
    ssi_pkg::ctx_t         sq_ctx_next;

    assign disc7 = cneg6_reg ? ({1'b0, hh6_reg} + {1'b0, ac6_reg})
                             : ({1'b0, hh6_reg} - {1'b0, ac6_reg});

    always_comb
    begin
        sq_ctx_next       = ctx6_reg;
        sq_ctx_next.miss  = ctx6_reg.miss || disc7[ssi_pkg::SQW];
        sq_ctx_next.dzero = (disc7 == '0);
    end

    logic                    sq_v_reg    [SW+1];
    ssi_pkg::ctx_t           sq_ctx_reg  [SW+1];
    logic [ssi_pkg::SQW-1:0] sq_disc_reg [SW+1];
    logic [SW-1:0]           sq_root_reg [SW+1];
    logic [RW-1:0]           sq_rem_reg  [SW+1];

    always_ff @(posedge clk)
    begin
        sq_ctx_reg[0]       <= sq_ctx_next;
        sq_disc_reg[0]      <= disc7[ssi_pkg::SQW-1:0];
        sq_root_reg[0]      <= '0;
        sq_rem_reg[0]       <= '0;
    end

    // ------------------------------------------------------------------
    // Square root of D * 2^(2P), one result bit per stage, most significant
    // first. The low 2P bits of the radicand are zero.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < SW; gi++)
    begin : g_sqrt
        localparam int J = SW - 1 - gi;
        logic [1:0]    pair;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic          take;

        if (J >= P)
        begin : g_data
            assign pair = sq_disc_reg[gi][2*(J-P)+1 -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign cur   = {sq_rem_reg[gi][RW-3:0], pair};
        assign trial = {sq_root_reg[gi], 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk)
        begin
            sq_rem_reg[gi+1]  <= take ? (cur - trial) : cur;
            sq_root_reg[gi+1] <= {sq_root_reg[gi][SW-2:0], take};
            sq_disc_reg[gi+1] <= sq_disc_reg[gi];
            sq_ctx_reg[gi+1]  <= sq_ctx_reg[gi];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[gi+1] <= 1'b0;
            else
                sq_v_reg[gi+1] <= sq_v_reg[gi];
        end
    end

    // ------------------------------------------------------------------
    // Numerators. Adding a * 2^(P+1) to -h*2^P -+ s keeps both numerators
    // non-negative inside the window, so the quotient is mu + 2^(P+1) and
    // needs only P+2 bits. Outside [0, a * 2^(P+2)) the root is rejected.
    // ------------------------------------------------------------------
    ssi_pkg::ctx_t         sq_ctx_out;
    logic signed [NW-1:0]  nm_hs;
    logic signed [NW-1:0]  nm_s;
    logic signed [NW-1:0]  nm_a1;
    logic [NW-1:0]         nm_lim;
    logic signed [NW-1:0]  nm_lo_next;
    logic signed [NW-1:0]  nm_hi_next;

    always_comb
    begin
        sq_ctx_out = sq_ctx_reg[SW];
        nm_hs      = -(NW'(sq_ctx_out.h) <<< P);
        nm_s       = $signed(NW'(sq_root_reg[SW]));
        nm_a1      = $signed(NW'(sq_ctx_out.a) << (P + 1));
        nm_lim     = NW'(sq_ctx_out.a) << (P + 2);
        nm_lo_next = nm_hs - nm_s + nm_a1;
        nm_hi_next = nm_hs + nm_s + nm_a1;
    end

    logic          dv_v_reg    [QS+1];
    ssi_pkg::ctx_t dv_ctx_reg  [QS+1];
    logic [NW-2:0] dv_rlo_reg  [QS+1];
    logic [NW-2:0] dv_rhi_reg  [QS+1];
    logic [QS-1:0] dv_qlo_reg  [QS+1];
    logic [QS-1:0] dv_qhi_reg  [QS+1];
    logic          dv_olo_reg  [QS+1];
    logic          dv_ohi_reg  [QS+1];

    always_ff @(posedge clk)
    begin
        dv_ctx_reg[0] <= sq_ctx_out;
        dv_rlo_reg[0] <= nm_lo_next[NW-2:0];
        dv_rhi_reg[0] <= nm_hi_next[NW-2:0];
        dv_qlo_reg[0] <= '0;
        dv_qhi_reg[0] <= '0;
        dv_olo_reg[0] <= nm_lo_next[NW-1] || ($unsigned(nm_lo_next) >= nm_lim);
        dv_ohi_reg[0] <= nm_hi_next[NW-1] || ($unsigned(nm_hi_next) >= nm_lim);
    end

    // Restoring division by a, one quotient bit per stage for each root.
    for (genvar gt = 0; gt < QS; gt++)
    begin : g_div
        localparam int K = QS - 1 - gt;
        logic [NW-2:0] den;
        logic          take_lo;
        logic          take_hi;

        assign den     = (NW - 1)'(dv_ctx_reg[gt].a) << K;
        assign take_lo = (dv_rlo_reg[gt] >= den);
        assign take_hi = (dv_rhi_reg[gt] >= den);

        always_ff @(posedge clk)
        begin
            dv_rlo_reg[gt+1] <= take_lo ? (dv_rlo_reg[gt] - den) : dv_rlo_reg[gt];
            dv_rhi_reg[gt+1] <= take_hi ? (dv_rhi_reg[gt] - den) : dv_rhi_reg[gt];
            dv_qlo_reg[gt+1] <= {dv_qlo_reg[gt][QS-2:0], take_lo};
            dv_qhi_reg[gt+1] <= {dv_qhi_reg[gt][QS-2:0], take_hi};
            dv_olo_reg[gt+1] <= dv_olo_reg[gt];
            dv_ohi_reg[gt+1] <= dv_ohi_reg[gt];
            dv_ctx_reg[gt+1] <= dv_ctx_reg[gt];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[gt+1] <= 1'b0;
            else
                dv_v_reg[gt+1] <= dv_v_reg[gt];
        end
    end

    // ------------------------------------------------------------------
    // Root choice. A tangent segment accepts mu in [EPS, 1]; otherwise the
    // smaller root inside (-EPS, 1 + EPS) wins.
    // ------------------------------------------------------------------
    logic [QS:0]   qlo_w;
    logic [QS:0]   qhi_w;
    logic          lo_win;
    logic          hi_win;
    logic          lo_tan;
    logic          sel_hit_next;
    logic [QS-1:0] sel_q;

    always_comb
    begin
        qlo_w  = {1'b0, dv_qlo_reg[QS]};
        qhi_w  = {1'b0, dv_qhi_reg[QS]};
        lo_win = !dv_olo_reg[QS] && (qlo_w > WIN_LO) && (qlo_w < WIN_HI);
        hi_win = !dv_ohi_reg[QS] && (qhi_w > WIN_LO) && (qhi_w < WIN_HI);
        lo_tan = !dv_olo_reg[QS] && (qlo_w >= Z_LO) && (qlo_w <= Z_HI);
        sel_hit_next = !dv_ctx_reg[QS].miss
                     && (dv_ctx_reg[QS].dzero ? lo_tan : (lo_win || hi_win));
        sel_q = (dv_ctx_reg[QS].dzero || lo_win) ? dv_qlo_reg[QS] : dv_qhi_reg[QS];
    end

    logic                 sel_v_reg;
    logic                 sel_hit_reg;
    logic signed [QS-1:0] sel_mu_reg;
    ssi_pkg::ctx_t        sel_ctx_reg;

    always_ff @(posedge clk)
    begin
        sel_hit_reg <= sel_hit_next;
        sel_mu_reg  <= sel_q - C0[QS-1:0];
        sel_ctx_reg <= dv_ctx_reg[QS];
    end

    // ------------------------------------------------------------------
    // Point: mu * d in two partial products, then floor shift, add, saturate.
    // ------------------------------------------------------------------
    logic                    ml_v_reg;
    logic                    ml_hit_reg;
    logic signed [49:0]      ml_lo_reg [3];
    logic signed [QS+16:0]   ml_hi_reg [3];
    logic [2:0][31:0]        ml_b_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ml_lo_reg[i] <= $signed({1'b0, sel_mu_reg[15:0]}) * $signed(sel_ctx_reg.d[i]);
            ml_hi_reg[i] <= $signed(sel_mu_reg[QS-1:16]) * $signed(sel_ctx_reg.d[i]);
        end
        ml_hit_reg <= sel_hit_reg;
        ml_b_reg   <= sel_ctx_reg.b;
    end

    logic                  sm_v_reg;
    logic                  sm_hit_reg;
    logic signed [PRW-1:0] sm_prod_reg [3];
    logic [2:0][31:0]      sm_b_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sm_prod_reg[i] <= (PRW'(ml_hi_reg[i]) <<< 16) + PRW'(ml_lo_reg[i]);
        sm_hit_reg <= ml_hit_reg;
        sm_b_reg   <= ml_b_reg;
    end

    logic signed [PTW-1:0] pt   [3];
    logic [31:0]           ptq  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = PTW'(sm_prod_reg[i] >>> P) + PTW'($signed(sm_b_reg[i]));
            if (pt[i][PTW-1:31] == '0 || pt[i][PTW-1:31] == '1)
                ptq[i] = pt[i][31:0];
            else if (pt[i][PTW-1])
                ptq[i] = 32'h8000_0000;
            else
                ptq[i] = 32'h7FFF_FFFF;
        end
    end

    logic          done_reg;
    ssi_pkg::res_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.hit   <= sm_hit_reg;
        result_reg.hit_x <= sm_hit_reg ? ptq[0] : '0;
        result_reg.hit_y <= sm_hit_reg ? ptq[1] : '0;
        result_reg.hit_z <= sm_hit_reg ? ptq[2] : '0;
    end

    // Valid bits of the fixed stages; the root and divide stages carry their own.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            sel_v_reg   <= 1'b0;
            ml_v_reg    <= 1'b0;
            sm_v_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            v1_reg      <= start && !busy;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            sq_v_reg[0] <= v6_reg;
            dv_v_reg[0] <= sq_v_reg[SW];
            sel_v_reg   <= dv_v_reg[QS];
            ml_v_reg    <= sel_v_reg;
            sm_v_reg    <= ml_v_reg;
            done_reg    <= sm_v_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `SSI_ASSERT_NOW(a_done_latency, clk, rst_n, done, $past(start, LAT))
    `SSI_ASSERT_NOW(a_miss_zero, clk, rst_n, done && !result.hit, result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0)
    `SSI_ASSERT_NEXT(a_radius_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == ssi_pkg::REG_RADIUS, rad_reg == $past(cfg_data[30:0]))

endmodule

// ----- sim/segment_sphere_intersection_core_tb.sv -----
// Self-checking testbench for segment_sphere_intersection_core: a queue-fed driver,
// a done-strobe monitor and an exact wide-integer predictor of hit and point.
// Depends on ssi_pkg and the core RTL only.
`timescale 1ns / 1ps

module segment_sphere_intersection_core_tb;

    import ssi_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam int    MU_BITS    = 30;
    localparam wide_t MU_ONE     = wide_t'(1) <<< MU_BITS;
    // 0.0001 in the root's fixed-point scale, rounded to nearest.
    localparam wide_t MU_EPS     = (MU_ONE + 5000) / 10000;
    localparam int    DRAIN_WAIT = 200;
    localparam int    CYCLE_CAP  = 600000;
    localparam int    RAND_ITEMS = 1500;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    seg_t        seg;
    logic        done;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;

    // Our copy of the sphere registers, updated on every config transfer.
    logic signed [31:0] sph_center [3];
    logic [30:0]        sph_radius;

    seg_t segs_pending [$];
    res_t hits_due [$];
    int   error_count;
    int   cycle_count;
    int   send_gap;
    bit   no_gaps;

    segment_sphere_intersection_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .seg       (seg),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Floor division for a positive divisor; SystemVerilog division truncates.
    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n < 0 && (n % d) != 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic wide_t int_sqrt(wide_t x_in);
        logic [255:0] x;
        logic [255:0] res;
        logic [255:0] bit_w;
        x     = x_in;
        res   = '0;
        bit_w = 256'd1 << 254;
        while (bit_w > x)
        begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != 0)
        begin
            if (x >= res + bit_w)
            begin
                x   = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
            begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return wide_t'(res);
    endfunction

    function automatic bit root_in_window(wide_t mu);
        return (mu > -MU_EPS) && (mu < MU_ONE + MU_EPS);
    endfunction

    // Intersection of one segment with the current sphere, exact in 256 bits.
    function automatic res_t sphere_hit(seg_t s);
        wide_t lo_pt [3];
        wide_t dir [3];
        wide_t off [3];
        wide_t qa;
        wide_t qh;
        wide_t qc;
        wide_t disc;
        wide_t hs;
        wide_t root;
        wide_t sq;
        wide_t lo;
        wide_t hi;
        wide_t p;
        wide_t rr;
        logic signed [31:0] axis [3];
        res_t r;
        lo_pt[0] = wide_t'(s.start_x);
        lo_pt[1] = wide_t'(s.start_y);
        lo_pt[2] = wide_t'(s.start_z);
        dir[0]   = wide_t'(s.stop_x) - lo_pt[0];
        dir[1]   = wide_t'(s.stop_y) - lo_pt[1];
        dir[2]   = wide_t'(s.stop_z) - lo_pt[2];
        rr       = wide_t'({1'b0, sph_radius});
        qa       = 0;
        qh       = 0;
        qc       = -(rr * rr);
        for (int i = 0; i < 3; i++)
        begin
            off[i] = lo_pt[i] - wide_t'(sph_center[i]);
            qa     = qa + dir[i] * dir[i];
            qh     = qh + dir[i] * off[i];
            qc     = qc + off[i] * off[i];
        end
        r = '0;
        if (qa == 0)
        begin
            return r;
        end
        disc = qh * qh - qa * qc;
        if (disc < 0)
        begin
            return r;
        end
        hs = (-qh) <<< MU_BITS;
        if (disc == 0)
        begin
            // Tangent: the one root must lie in [eps, 1].
            root = floor_div(hs, qa);
            if (root < MU_EPS || root > MU_ONE)
            begin
                return r;
            end
        end
        else
        begin
            sq = int_sqrt(disc <<< (2 * MU_BITS));
            lo = floor_div(hs - sq, qa);
            hi = floor_div(hs + sq, qa);
            if (root_in_window(lo))
            begin
                root = lo;
            end
            else if (root_in_window(hi))
            begin
                root = hi;
            end
            else
            begin
                return r;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            p = ((root * dir[i]) >>> MU_BITS) + lo_pt[i];
            if (p < -wide_t'(64'h8000_0000))
            begin
                axis[i] = 32'sh8000_0000;
            end
            else if (p > wide_t'(64'h7FFF_FFFF))
            begin
                axis[i] = 32'sh7FFF_FFFF;
            end
            else
            begin
                axis[i] = p[31:0];
            end
        end
        r.hit   = 1'b1;
        r.hit_x = axis[0];
        r.hit_y = axis[1];
        r.hit_z = axis[2];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_gaps)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Driver: the prediction is made on the transfer, then the next segment
    // (or a gap) is set up with a single assignment to start per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            seg      <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                hits_due.push_back(sphere_hit(seg));
            end
            if (!(start && busy))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    start    <= 1'b0;
                end
                else if (segs_pending.size() > 0)
                begin
                    seg      <= segs_pending.pop_front();
                    start    <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every done strobe is checked.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (hits_due.size() == 0)
            begin
                $display("%0t: result with none expected: actual %p", $time, result);
                error_count++;
            end
            else
            begin
                want = hits_due.pop_front();
                if (result.hit !== want.hit || result.hit_x !== want.hit_x
                    || result.hit_y !== want.hit_y || result.hit_z !== want.hit_z)
                begin
                    $display("%0t: mismatch: expected %p actual %p", $time, want, result);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[segment_sphere_intersection_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_center[0] = value;
            REG_CENTER_Y: sph_center[1] = value;
            REG_CENTER_Z: sph_center[2] = value;
            REG_RADIUS:   sph_radius = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
    endtask

    // Waits until the queue is empty and every predicted result has arrived,
    // then lets the pipeline run dry before the registers change.
    task automatic drain();
        while (segs_pending.size() > 0 || start || hits_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic seg_t mk_seg(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        seg_t s;
        s.start_x = ax;
        s.start_y = ay;
        s.start_z = az;
        s.stop_x  = bx;
        s.stop_y  = by;
        s.stop_z  = bz;
        return s;
    endfunction

    // Mostly segments around the sphere, with tangents, points and raw noise mixed in.
    function automatic seg_t random_seg();
        longint span;
        longint c [3];
        longint pt [6];
        int     roll;
        seg_t   s;
        span = longint'(sph_radius) * 3 + 16;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = longint'(sph_center[i]);
        end
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else if (roll < 20)
        begin
            // Tangent along x at the top of the sphere, reaching two radii either side of the center.
            span = longint'(sph_radius);
            s = mk_seg(clamp32(c[0] - 2 * span), clamp32(c[1] + span), clamp32(c[2]),
                       clamp32(c[0] + 2 * span), clamp32(c[1] + span), clamp32(c[2]));
        end
        else if (roll < 25)
        begin
            s.start_x = clamp32(c[0] + ($signed($urandom) % span));
            s.start_y = clamp32(c[1] + ($signed($urandom) % span));
            s.start_z = clamp32(c[2] + ($signed($urandom) % span));
            s.stop_x  = s.start_x;
            s.stop_y  = s.start_y;
            s.stop_z  = s.start_z;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                pt[i] = c[i % 3] + (longint'($signed($urandom)) % span);
            end
            s = mk_seg(clamp32(pt[0]), clamp32(pt[1]), clamp32(pt[2]),
                       clamp32(pt[3]), clamp32(pt[4]), clamp32(pt[5]));
        end
        return s;
    endfunction

    task automatic random_phase(int count);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) segs_pending.push_back(random_seg());
        drain();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CENTER_X;
        cfg_data      = '0;
        error_count   = 0;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        sph_center[0] = '0;
        sph_center[1] = '0;
        sph_center[2] = '0;
        sph_radius    = 31'd65536;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases against the reset sphere: unit radius at the origin.
        segs_pending.push_back(mk_seg(-32'sd131072, 0, 0, 32'sd131072, 0, 0));
        segs_pending.push_back(mk_seg(0, 0, 0, 32'sd131072, 0, 0));
        segs_pending.push_back(mk_seg(-32'sd131072, 32'sd65536, 0, 32'sd131072, 32'sd65536, 0));
        segs_pending.push_back(mk_seg(32'sd131072, 32'sd65536, 0, 32'sd131072, 32'sd65536, 0));
        segs_pending.push_back(mk_seg(0, 32'sd65536, 0, 32'sd131072, 32'sd65536, 0));
        segs_pending.push_back(mk_seg(-32'sd131072, 32'sd131072, 0, 32'sd131072, 32'sd131072, 0));
        segs_pending.push_back(mk_seg(32'sd131072, 0, 0, 32'sd262144, 0, 0));
        segs_pending.push_back(mk_seg(0, 0, -32'sd131072, 0, 0, -32'sd65536));
        segs_pending.push_back(mk_seg(0, 0, -32'sd65531, 0, 0, 32'sd65536));
        segs_pending.push_back(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        segs_pending.push_back(mk_seg(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
        segs_pending.push_back(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        segs_pending.push_back('1);
        segs_pending.push_back('0);
        // The sender stops here until every result so far is back.
        drain();

        // Writes to indexes past the register list must change nothing.
        for (int k = 4; k < 8; k++)
        begin
            write_reg(cfg_idx_t'(k), $urandom);
        end
        segs_pending.push_back(mk_seg(-32'sd131072, 0, 0, 32'sd131072, 0, 0));
        drain();

        // Largest sphere, centered at the most negative corner; points saturate.
        set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        segs_pending.push_back(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        segs_pending.push_back(mk_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        random_phase(150);

        // Zero radius at the most positive corner: only tangent-like touches.
        set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        segs_pending.push_back(mk_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h0, 32'h0, 32'h0));
        random_phase(100);

        // Random spheres of every scale.
        for (int ph = 0; ph < 10; ph++)
        begin
            set_sphere($signed($urandom) >>> $urandom_range(0, 12),
                       $signed($urandom) >>> $urandom_range(0, 12),
                       $signed($urandom) >>> $urandom_range(0, 12),
                       $urandom_range(1, 1 << $urandom_range(4, 28)));
            random_phase((RAND_ITEMS - 250) / 10);
        end

        if (error_count == 0)
        begin
            $display("[segment_sphere_intersection_core] OK");
        end
        else
        begin
            $display("[segment_sphere_intersection_core] ERROR");
        end
        $finish;
    end

endmodule
